/* sv/pcm_float_sample_converter_defines.svh */
// Assertion helpers for the converter top module.
`ifndef PCM_FLOAT_SAMPLE_CONVERTER_DEFINES_SVH
`define PCM_FLOAT_SAMPLE_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PFSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pfsc assertion failed");
`define PFSC_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("pfsc assertion failed");
`else
`define PFSC_ASSERT(lbl, prop)
`define PFSC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* sv/pfsc_pkg.sv */
package pfsc_pkg;

	localparam int WORD_W = 32;

	localparam logic CFG_FORMAT_IS_FLOAT = 1'b0;
	localparam logic CFG_PCM_WIDTH_IS_32 = 1'b1;

	localparam logic [7:0] EXP_ONE = 8'd127;
	localparam logic [7:0] EXP_MAX = 8'd255;
	localparam logic [7:0] EXP_BIAS_I32 = 8'd96;
	localparam logic [7:0] EXP_BIAS_I16 = 8'd112;
	localparam logic [7:0] MUL_SHIFT_BASE = 8'd150;
	localparam logic [14:0] SCALE_I16 = 15'd32767;

	typedef struct packed {
		logic action;
		logic [WORD_W-1:0] sample_word;
		logic last_in;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic clamped;
		logic last_out;
	} out_t;

endpackage

/* sv/pcm_float_sample_converter.sv */
// One sample enters per cycle and its result appears on result with done high once it
// has passed the input register and the result register, with the integer/float
// conversion logic between them. busy is always low and results cannot be held
// off, so the receiver must take every done beat. Config writes take effect on
// the next cycle and should only be made while no sample is in flight.
`include "pcm_float_sample_converter_defines.svh"

module pcm_float_sample_converter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pfsc_pkg::in_t   sample_in,
	output logic            done,
	output pfsc_pkg::out_t  result,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic            cfg_data
);

	logic           fmt_float_q;
	logic           width32_q;
	logic           valid_s1;
	pfsc_pkg::in_t  item_s1;
	logic [31:0]    to_flt;
	logic [31:0]    to_int;
	logic           to_int_clamp;
	pfsc_pkg::out_t res_next;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_float_q <= 1'b0;
			width32_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfsc_pkg::CFG_FORMAT_IS_FLOAT: fmt_float_q <= cfg_data;
				pfsc_pkg::CFG_PCM_WIDTH_IS_32: width32_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= sample_in;
		end
		if (valid_s1) begin
			result <= res_next;
		end
	end

	pfsc_int2flt u_int2flt (
		.word (item_s1.sample_word),
		.is32 (width32_q),
		.flt  (to_flt)
	);

	pfsc_flt2int u_flt2int (
		.word  (item_s1.sample_word),
		.is32  (width32_q),
		.res   (to_int),
		.clamp (to_int_clamp)
	);

	always_comb begin
		res_next.last_out = item_s1.last_in;
		if (fmt_float_q) begin
			res_next.result_word = item_s1.sample_word;
			res_next.clamped = 1'b0;
		end else if (!item_s1.action) begin
			res_next.result_word = to_flt;
			res_next.clamped = 1'b0;
		end else begin
			res_next.result_word = to_int;
			res_next.clamped = to_int_clamp;
		end
	end

	`PFSC_ASSERT_NEXT(a_accept_to_s1, start && !busy, valid_s1)
	`PFSC_ASSERT_NEXT(a_s1_to_done, valid_s1, done)
	`PFSC_ASSERT(a_clamp_full_scale, done && result.clamped |-> (result.result_word == 32'h7FFFFFFF || result.result_word == 32'h80000001 || result.result_word == 32'h00007FFF || result.result_word == 32'h00008001))
	`PFSC_ASSERT(a_float_no_clamp, done && fmt_float_q |-> !result.clamped)

endmodule

/* sv/pfsc_int2flt.sv */
module pfsc_int2flt (
	input  logic [31:0] word,
	input  logic        is32,
	output logic [31:0] flt
);

	logic        sgn;
	logic [31:0] mag;
	logic [4:0]  msb;
	logic [31:0] norm;
	logic        rnd_up;
	logic [24:0] sig;
	logic [7:0]  expo;

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) begin
				msb = 5'(i);
			end
		end
	end

	always_comb begin
		if (is32) begin
			sgn = word[31];
			mag = sgn ? (32'd0 - word) : word;
		end else begin
			sgn = word[15];
			mag = {16'd0, sgn ? (16'd0 - word[15:0]) : word[15:0]};
		end
		norm = mag << (5'd31 - msb);
		rnd_up = norm[7] && ((|norm[6:0]) || norm[8]);
		sig = {1'b0, norm[31:8]} + {24'd0, rnd_up};
		expo = (is32 ? pfsc_pkg::EXP_BIAS_I32 : pfsc_pkg::EXP_BIAS_I16) + {3'd0, msb};
		// Rounding can carry into a new leading bit; the fraction is then zero.
		if (sig[24]) begin
			expo = expo + 8'd1;
		end
		if (mag == 32'd0) begin
			flt = 32'd0;
		end else begin
			flt = {sgn, expo, sig[22:0]};
		end
	end

endmodule

/* sv/pfsc_flt2int.sv */
module pfsc_flt2int (
	input  logic [31:0] word,
	input  logic        is32,
	output logic [31:0] res,
	output logic        clamp
);

	logic        sgn;
	logic [7:0]  e;
	logic [22:0] f;
	logic        nan;
	logic        over;
	logic [7:0]  me;
	logic [23:0] mm;
	logic [7:0]  sh;
	logic [54:0] p31;
	logic [31:0] mag32;
	logic [38:0] p16;
	logic [39:0] pr16;
	logic        g16;
	logic        lsb16;
	logic        st16;
	logic [15:0] mag16;

	always_comb begin
		sgn = word[31];
		e = word[30:23];
		f = word[22:0];
		nan = (e == pfsc_pkg::EXP_MAX) && (f != 23'd0);
		over = (e > pfsc_pkg::EXP_ONE) || ((e == pfsc_pkg::EXP_ONE) && (f != 23'd0));
		// Out of range values are replaced by exactly one.
		me = over ? pfsc_pkg::EXP_ONE : e;
		mm = over ? 24'h800000 : {e != 8'd0, f};
		sh = pfsc_pkg::MUL_SHIFT_BASE - me;

		p31 = {mm, 31'd0} - {31'd0, mm};
		mag32 = (sh >= 8'd55) ? 32'd0 : 32'(p31 >> sh);

		// Product by 32767 is rounded to 24 significant bits before truncation.
		p16 = {15'd0, mm} * {24'd0, pfsc_pkg::SCALE_I16};
		if (p16[38]) begin
			lsb16 = p16[15];
			g16 = p16[14];
			st16 = |p16[13:0];
			pr16 = {1'b0, p16[38:15], 15'd0} +
				((g16 && (st16 || lsb16)) ? 40'h8000 : 40'd0);
		end else begin
			lsb16 = p16[14];
			g16 = p16[13];
			st16 = |p16[12:0];
			pr16 = {1'b0, p16[38:14], 14'd0} +
				((g16 && (st16 || lsb16)) ? 40'h4000 : 40'd0);
		end
		mag16 = (sh >= 8'd40) ? 16'd0 : 16'(pr16 >> sh);

		if (nan) begin
			res = 32'd0;
		end else if (is32) begin
			res = sgn ? (32'd0 - mag32) : mag32;
		end else begin
			res = {16'd0, sgn ? (16'd0 - mag16) : mag16};
		end
		clamp = over && !nan;
	end

endmodule

/* bench/tb_top.sv */
module tb_top;

	localparam logic ACT_TO_FLOAT = 1'b0;
	localparam logic ACT_FROM_FLOAT = 1'b1;
	localparam int SETTLE_CYCLES = 6;
	localparam int WANT_DEPTH = 2048;

	typedef struct {
		logic cfg_float;
		logic cfg_32;
		logic action;
		logic [31:0] word;
		logic last;
		logic known;
		logic [31:0] want_word;
		logic want_clamp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pfsc_pkg::in_t sample_in;
	logic done;
	pfsc_pkg::out_t result;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;

	logic mode_float;
	logic mode_32;
	pfsc_pkg::out_t want_mem[WANT_DEPTH];
	int wr_count;
	int rd_count;
	int mismatches;

	logic [1:0] phase_modes[8] = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00, 2'b01, 2'b00, 2'b01};

	pcm_float_sample_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_in(sample_in),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Signed integer magnitude to single float, round to nearest even, scaled by 2^-scale.
	function automatic logic [31:0] int_to_float(logic sign, logic [63:0] mag, int scale);
		int msb;
		int d;
		logic [63:0] mant;
		logic [63:0] rem;
		logic [63:0] half;
		if (mag == 0)
			return 32'h0;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i])
				msb = i;
		if (msb > 23) begin
			d = msb - 23;
			mant = mag >> d;
			rem = mag & ((64'd1 << d) - 1);
			half = 64'd1 << (d - 1);
			if (rem > half || (rem == half && mant[0]))
				mant = mant + 1;
			if (mant[24]) begin
				mant = mant >> 1;
				msb = msb + 1;
			end
		end else begin
			mant = mag << (23 - msb);
		end
		return {sign, 8'(msb + 127 - scale), mant[22:0]};
	endfunction

	// Float magnitude below one times 32767, rounded to a float, then truncated.
	function automatic logic [15:0] scale_to_i16(logic [31:0] w);
		logic [63:0] prod;
		logic [63:0] rounded;
		logic [63:0] rem;
		logic [63:0] half;
		int msb;
		int d;
		int sh;
		if (w[30:23] == 8'd0)
			return 16'h0;
		prod = {40'd0, 1'b1, w[22:0]} * 64'd32767;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (prod[i])
				msb = i;
		d = msb - 23;
		rounded = prod >> d;
		rem = prod & ((64'd1 << d) - 1);
		half = 64'd1 << (d - 1);
		if (rem > half || (rem == half && rounded[0]))
			rounded = rounded + 1;
		sh = 150 - int'(w[30:23]) - d;
		if (sh >= 64)
			rounded = 64'd0;
		else if (sh > 0)
			rounded = rounded >> sh;
		else
			rounded = rounded << (-sh);
		return w[31] ? 16'(-rounded) : rounded[15:0];
	endfunction

	function automatic logic [31:0] scale_to_i32(logic [31:0] w);
		logic [63:0] prod;
		int sh;
		if (w[30:23] == 8'd0)
			return 32'h0;
		prod = {40'd0, 1'b1, w[22:0]} * 64'd2147483647;
		sh = 150 - int'(w[30:23]);
		prod = (sh >= 64) ? 64'd0 : prod >> sh;
		return w[31] ? 32'(-prod) : prod[31:0];
	endfunction

	function automatic pfsc_pkg::out_t convert_sample(pfsc_pkg::in_t s);
		pfsc_pkg::out_t r;
		logic [31:0] w;
		logic [15:0] lo;
		logic [63:0] mag;
		w = s.sample_word;
		r.result_word = 32'h0;
		r.clamped = 1'b0;
		r.last_out = s.last_in;
		if (mode_float) begin
			r.result_word = w;
		end else if (s.action == ACT_TO_FLOAT) begin
			if (mode_32) begin
				mag = w[31] ? 64'(-{32'hFFFF_FFFF, w}) : {32'd0, w};
				r.result_word = int_to_float(w[31], mag, 31);
			end else begin
				lo = w[15:0];
				mag = lo[15] ? 64'(-{48'hFFFF_FFFF_FFFF, lo}) : {48'd0, lo};
				r.result_word = int_to_float(lo[15], mag, 15);
			end
		end else if (w[30:23] == 8'hFF && w[22:0] != 0) begin
			r.result_word = 32'h0;
		end else if (w[30:0] >= 31'h3F80_0000) begin
			r.clamped = (w[30:0] != 31'h3F80_0000);
			if (mode_32)
				r.result_word = w[31] ? 32'h8000_0001 : 32'h7FFF_FFFF;
			else
				r.result_word = w[31] ? 32'h0000_8001 : 32'h0000_7FFF;
		end else if (mode_32) begin
			r.result_word = scale_to_i32(w);
		end else begin
			r.result_word = {16'h0, scale_to_i16(w)};
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		pfsc_pkg::out_t want;
		if (arst_n && done) begin
			if (wr_count == rd_count) begin
				report_mismatch($sformatf("unexpected beat word=%h", result.result_word));
			end else begin
				want = want_mem[rd_count % WANT_DEPTH];
				rd_count++;
				if (result.result_word !== want.result_word)
					report_mismatch($sformatf("result_word got %h want %h",
						result.result_word, want.result_word));
				if (result.clamped !== want.clamped)
					report_mismatch($sformatf("clamped got %b want %b for word %h",
						result.clamped, want.clamped, want.result_word));
				if (result.last_out !== want.last_out)
					report_mismatch($sformatf("last_out got %b want %b",
						result.last_out, want.last_out));
			end
		end
	end

	task automatic wait_idle();
		while (wr_count != rd_count)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The caller drops the write enable after its last write.
	task automatic write_reg(logic idx, logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == pfsc_pkg::CFG_FORMAT_IS_FLOAT)
			mode_float = val;
		else
			mode_32 = val;
	endtask

	task automatic set_mode(logic is_float, logic is_32);
		start <= 1'b0;
		wait_idle();
		write_reg(pfsc_pkg::CFG_FORMAT_IS_FLOAT, is_float);
		write_reg(pfsc_pkg::CFG_PCM_WIDTH_IS_32, is_32);
		cfg_we <= 1'b0;
	endtask

	// Holds start high until the beat is taken; start stays high for a following beat.
	task automatic send_sample(pfsc_pkg::in_t s, pfsc_pkg::out_t want);
		start <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (busy);
		want_mem[wr_count % WANT_DEPTH] = want;
		wr_count++;
	endtask

	function automatic logic [31:0] random_word(logic action);
		int pick;
		logic [31:0] w;
		w = $urandom;
		if (action == ACT_TO_FLOAT)
			return w;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: return w;
			2: begin
				w[30:0] = 31'h3F80_0000;
				return w;
			end
			3: begin
				w[30:23] = 8'hFF;
				w[22:0] = ($urandom_range(0, 1) == 0) ? 23'h0 : w[22:0];
				return w;
			end
			4: begin
				w[30:23] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'(128 + $urandom_range(0, 30));
				return w;
			end
			default: begin
				w[30:23] = 8'($urandom_range(90, 126));
				return w;
			end
		endcase
	endfunction

	stim_row_t directed[23] = '{
		'{0, 0, ACT_TO_FLOAT, 32'h0000_0000, 0, 1, 32'h0000_0000, 0},
		'{0, 0, ACT_TO_FLOAT, 32'h0000_8000, 1, 1, 32'hBF80_0000, 0},
		'{0, 0, ACT_TO_FLOAT, 32'h0000_7FFF, 0, 0, 32'h0, 0},
		'{0, 0, ACT_TO_FLOAT, 32'hFFFF_0001, 0, 0, 32'h0, 0},
		'{0, 0, ACT_FROM_FLOAT, 32'h3F80_0000, 0, 1, 32'h0000_7FFF, 0},
		'{0, 0, ACT_FROM_FLOAT, 32'hBF80_0000, 1, 1, 32'h0000_8001, 0},
		'{0, 0, ACT_FROM_FLOAT, 32'h7F80_0000, 0, 1, 32'h0000_7FFF, 1},
		'{0, 0, ACT_FROM_FLOAT, 32'hFF80_0000, 0, 1, 32'h0000_8001, 1},
		'{0, 0, ACT_FROM_FLOAT, 32'h7FC0_0000, 0, 1, 32'h0000_0000, 0},
		'{0, 0, ACT_FROM_FLOAT, 32'h4000_0000, 0, 1, 32'h0000_7FFF, 1},
		'{0, 0, ACT_FROM_FLOAT, 32'h0000_0001, 0, 1, 32'h0000_0000, 0},
		'{0, 0, ACT_FROM_FLOAT, 32'h3F00_0000, 1, 0, 32'h0, 0},
		'{0, 1, ACT_TO_FLOAT, 32'h8000_0000, 0, 1, 32'hBF80_0000, 0},
		'{0, 1, ACT_TO_FLOAT, 32'h7FFF_FFFF, 0, 1, 32'h3F80_0000, 0},
		'{0, 1, ACT_TO_FLOAT, 32'h0000_0000, 1, 1, 32'h0000_0000, 0},
		'{0, 1, ACT_TO_FLOAT, 32'h0000_0001, 0, 0, 32'h0, 0},
		'{0, 1, ACT_FROM_FLOAT, 32'h3F80_0000, 0, 1, 32'h7FFF_FFFF, 0},
		'{0, 1, ACT_FROM_FLOAT, 32'hBF80_0000, 0, 1, 32'h8000_0001, 0},
		'{0, 1, ACT_FROM_FLOAT, 32'hFF80_0000, 1, 1, 32'h8000_0001, 1},
		'{0, 1, ACT_FROM_FLOAT, 32'h7FC0_0001, 0, 1, 32'h0000_0000, 0},
		'{0, 1, ACT_FROM_FLOAT, 32'h3F7F_FFFF, 0, 0, 32'h0, 0},
		'{1, 0, ACT_TO_FLOAT, 32'hDEAD_BEEF, 1, 1, 32'hDEAD_BEEF, 0},
		'{1, 1, ACT_FROM_FLOAT, 32'h7FC0_0000, 0, 1, 32'h7FC0_0000, 0}
	};

	initial begin
		pfsc_pkg::in_t s;
		pfsc_pkg::out_t want;
		int burst;
		arst_n = 1'b0;
		start = 1'b0;
		sample_in = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		mode_float = 1'b0;
		mode_32 = 1'b0;
		wr_count = 0;
		rd_count = 0;
		mismatches = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state is 16-bit integer, so the first rows run before any write.
		foreach (directed[i]) begin
			if (directed[i].cfg_float !== mode_float || directed[i].cfg_32 !== mode_32)
				set_mode(directed[i].cfg_float, directed[i].cfg_32);
			s.action = directed[i].action;
			s.sample_word = directed[i].word;
			s.last_in = directed[i].last;
			want = convert_sample(s);
			if (directed[i].known) begin
				want.result_word = directed[i].want_word;
				want.clamped = directed[i].want_clamp;
			end
			send_sample(s, want);
		end

		foreach (phase_modes[p]) begin
			set_mode(phase_modes[p][1], phase_modes[p][0]);
			for (int n = 0; n < 220; ) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && n < 220; b++, n++) begin
					s.action = 1'($urandom_range(0, 1));
					s.sample_word = random_word(s.action);
					s.last_in = ($urandom_range(0, 7) == 0);
					send_sample(s, convert_sample(s));
				end
				if ($urandom_range(0, 3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		wait_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
